FILE: rtl/pst_pkg.sv
// Package for the spanning tree block: sizes, types and the action codes.
// Used by every module in rtl/.
`default_nettype none
package pst_pkg;
   localparam int MAX_VERTICES = 16;
   localparam int WEIGHT_BITS  = 16;
   localparam int VTX_BITS     = $clog2(MAX_VERTICES);
   localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
   localparam int MAT_DEPTH    = MAX_VERTICES * MAX_VERTICES;
   localparam int MAT_BITS     = $clog2(MAT_DEPTH);
   localparam logic [WEIGHT_BITS-1:0] NO_EDGE = '1;

   // Minimum search: a register after every TAP_SPAN cells of the chain.
   localparam int TAP_SPAN     = 4;
   localparam int SCAN_CYCLES  = (MAX_VERTICES + TAP_SPAN - 1) / TAP_SPAN;
   localparam int WAIT_BITS    = $clog2(SCAN_CYCLES + 1);

   localparam logic [2:0] ADDR_VCOUNT = 3'd0;

   typedef enum logic {ACT_LOAD = 1'b0, ACT_RUN = 1'b1} action_type;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_LOAD2, ST_INIT, ST_SCAN, ST_EMIT, ST_UPDATE, ST_DONE
   } state_type;

   // Control from the sequencer to the cell chain.
   typedef struct packed {
      logic                  init;     // load best distance from row word
      logic                  update;   // relax against row word
      logic                  mark;     // put vertex sel into the tree
      logic [VTX_BITS-1:0]   sel;
      logic [VTX_BITS-1:0]   src;      // vertex whose row is streaming
      logic [VTX_BITS-1:0]   col;      // column of the streaming word
      logic [WEIGHT_BITS-1:0] w;
      logic [CNT_BITS-1:0]   n;
   } cell_ctl_type;

   // Minimum search result carried along the chain.
   typedef struct packed {
      logic                   found;
      logic [WEIGHT_BITS-1:0] cost;
      logic [VTX_BITS-1:0]    idx;
      logic [VTX_BITS-1:0]    pred;
   } scan_type;
endpackage
`default_nettype wire

FILE: rtl/pst_cell.sv
// One vertex cell: best distance, predecessor and tree flag of one vertex.
// Depends on pst_pkg; takes the running minimum from its left neighbor.
`default_nettype none
module pst_cell (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [pst_pkg::VTX_BITS-1:0] my_idx,
   input  wire pst_pkg::cell_ctl_type    ctl,
   input  wire pst_pkg::scan_type        scan_left,
   output pst_pkg::scan_type             scan_right
);
   import pst_pkg::*;

   logic [WEIGHT_BITS-1:0] dist_ff;
   logic [VTX_BITS-1:0]    pred_ff;
   logic                   tree_ff, tree_in;
   logic                   active, hit;

   assign active = {1'b0, my_idx} < ctl.n;
   assign hit    = ctl.col == my_idx;

   always_comb begin
      tree_in = tree_ff;
      if (ctl.init && hit) begin
         tree_in = ctl.src == my_idx;
      end else if (ctl.mark && ctl.sel == my_idx) begin
         tree_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tree_ff <= 1'b0;
      end else begin
         tree_ff <= tree_in;
      end
      if (hit && ctl.init) begin
         dist_ff <= ctl.w;
         pred_ff <= ctl.src;
      end else if (hit && ctl.update && !tree_ff && ctl.w < dist_ff) begin
         dist_ff <= ctl.w;
         pred_ff <= ctl.src;
      end
   end

   // strict less keeps the lowest index on ties
   always_comb begin
      scan_right = scan_left;
      if (active && !tree_ff && dist_ff < scan_left.cost) begin
         scan_right.found = 1'b1;
         scan_right.cost  = dist_ff;
         scan_right.idx   = my_idx;
         scan_right.pred  = pred_ff;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/pst_chain.sv
// Row of vertex cells with registered minimum taps every four cells.
// Depends on pst_pkg and pst_cell.
`default_nettype none
module pst_chain (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pst_pkg::cell_ctl_type ctl,
   output pst_pkg::scan_type          best
);
   import pst_pkg::*;

   scan_type link [MAX_VERTICES+1];
   scan_type cell_out [MAX_VERTICES];

   assign link[0] = '{found: 1'b0, cost: NO_EDGE, idx: '0, pred: '0};

   for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
      pst_cell u_cell (
         .clock,
         .reset,
         .my_idx    (VTX_BITS'(g)),
         .ctl,
         .scan_left (link[g]),
         .scan_right(cell_out[g])
      );
      // register the running minimum at the end of each group of cells
      if (g % TAP_SPAN == TAP_SPAN - 1 || g == MAX_VERTICES - 1) begin : g_tap
         scan_type tap_ff;
         always_ff @(posedge clock) begin
            tap_ff <= cell_out[g];
         end
         assign link[g+1] = tap_ff;
      end else begin : g_pass
         assign link[g+1] = cell_out[g];
      end
   end

   assign best = link[MAX_VERTICES];
endmodule
`default_nettype wire

FILE: rtl/prim_spanning_tree.sv
// Top level: stream ports, vertex_count register, weight memory and sequencer.
// Depends on pst_pkg, pst_chain.
//
// A load word writes both symmetric cells, the first in the accepting cycle and
// the second in ST_LOAD2. A run streams the start row; then each tree edge
// takes a pipelined minimum search, the issue of the result word and, but for
// the last edge, the streaming of the new vertex's row from the weight memory.
// The single read port of the weight memory, one row word per cycle, sets the
// row time; a result word held back by the sink stalls the run until taken.
// The action travels in req_tuser and edge_valid in rsp_tuser. After reset a
// clearing pass writes the no-edge value into all 256 words of the memory;
// no word is taken during it.
`default_nettype none
module prim_spanning_tree (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // action
   input  wire logic        req_tuser,
   // row_vertex [3:0], col_vertex [7:4], weight [23:8], start_vertex [27:24]
   input  wire logic [31:0] req_tdata,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // from_vertex [3:0], to_vertex [7:4], edge_weight [23:8]
   output      logic [31:0] rsp_tdata,
   // edge_valid
   output      logic        rsp_tuser,
   output      logic        rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);
   import pst_pkg::*;

   // config
   logic [4:0] vcount_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ADDR_VCOUNT) ? {27'd0, vcount_ff} : '0;
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= 5'd16;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == ADDR_VCOUNT) begin
         vcount_ff <= csr_pwdata[4:0];
      end
   end

   logic [CNT_BITS-1:0] n_eff;
   always_comb begin
      if (vcount_ff == 5'd0) begin
         n_eff = CNT_BITS'(1);
      end else if ({1'b0, vcount_ff} > 6'(MAX_VERTICES)) begin
         n_eff = CNT_BITS'(MAX_VERTICES);
      end else begin
         n_eff = CNT_BITS'(vcount_ff);
      end
   end

   // input fields
   logic                   in_act;
   logic [VTX_BITS-1:0]    in_row, in_col, in_start;
   logic [WEIGHT_BITS-1:0] in_w;
   assign in_act   = req_tuser;
   assign in_row   = req_tdata[3:0];
   assign in_col   = req_tdata[7:4];
   assign in_w     = req_tdata[23:8];
   assign in_start = req_tdata[27:24];

   // weight memory
   logic [WEIGHT_BITS-1:0] mem [MAT_DEPTH];
   logic                   mem_we;
   logic [MAT_BITS-1:0]    mem_waddr, mem_raddr;
   logic [WEIGHT_BITS-1:0] mem_wdata, mem_rdata_ff;
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

   state_type state_ff, state_in;
   logic [MAT_BITS-1:0]    clr_ff;
   logic [VTX_BITS-1:0]    a_ff, b_ff, src_ff, cnt_ff;
   logic [WEIGHT_BITS-1:0] w_ff;
   logic [CNT_BITS-1:0]    step_ff, n_ff;
   logic                   rd_v_ff;    // memory word valid this cycle
   logic [VTX_BITS-1:0]    rd_col_ff;
   logic                   rd_last_ff;
   logic [WAIT_BITS-1:0]   wait_ff;
   logic                   rsp_v_ff, rsp_last_ff, rsp_ev_ff;
   logic [VTX_BITS-1:0]    rsp_from_ff, rsp_to_ff;
   logic [WEIGHT_BITS-1:0] rsp_w_ff;

   cell_ctl_type ctl;
   scan_type     best;

   pst_chain u_chain (.clock, .reset, .ctl, .best);

   assign req_tready = state_ff == ST_IDLE && !rsp_v_ff;
   logic take;
   assign take = req_tvalid && req_tready;

   logic bad_run;
   assign bad_run = {1'b0, in_start} >= n_eff || n_eff == CNT_BITS'(1);

   logic row_done;
   assign row_done = rd_v_ff && rd_last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clr_ff == MAT_BITS'(MAT_DEPTH - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (take) begin
               if (in_act == ACT_LOAD) begin
                  state_in = ST_LOAD2;
               end else if (!bad_run) begin
                  state_in = ST_INIT;
               end
            end
         end
         ST_LOAD2:  state_in = ST_IDLE;
         ST_INIT:   if (row_done) state_in = ST_SCAN;
         // wait for the minimum to pass every tap of the chain
         ST_SCAN:   if (wait_ff == WAIT_BITS'(SCAN_CYCLES - 1)) state_in = ST_EMIT;
         ST_EMIT: begin
            if (!rsp_v_ff) begin
               if (!best.found || step_ff == n_ff - CNT_BITS'(1)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: if (row_done) state_in = ST_SCAN;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs / memory control
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = {in_row, in_col};
      mem_wdata = in_w;
      mem_raddr = {src_ff, cnt_ff};
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = NO_EDGE;
         end
         ST_IDLE:  mem_we = take && in_act == ACT_LOAD;
         ST_LOAD2: begin
            mem_we    = 1'b1;
            mem_waddr = {b_ff, a_ff};
            mem_wdata = w_ff;
         end
         default: ;
      endcase
   end

   assign ctl.init   = state_ff == ST_INIT && rd_v_ff;
   assign ctl.update = state_ff == ST_UPDATE && rd_v_ff;
   assign ctl.mark   = state_ff == ST_EMIT && !rsp_v_ff && best.found;
   assign ctl.sel    = best.idx;
   assign ctl.src    = src_ff;
   assign ctl.col    = rd_col_ff;
   assign ctl.w      = mem_rdata_ff;
   assign ctl.n      = n_ff;

   logic issuing;
   assign issuing = (state_ff == ST_INIT || state_ff == ST_UPDATE)
                    && {1'b0, cnt_ff} < n_ff && !(rd_v_ff && rd_last_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         rsp_v_ff <= 1'b0;
         rd_v_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + MAT_BITS'(1);
         rd_v_ff <= issuing;
         if (rsp_v_ff && rsp_tready) begin
            rsp_v_ff <= 1'b0;
         end else if (state_ff == ST_IDLE && take && in_act == ACT_RUN && bad_run) begin
            rsp_v_ff <= 1'b1;
         end else if (state_ff == ST_EMIT && !rsp_v_ff) begin
            rsp_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_col_ff  <= cnt_ff;
      rd_last_ff <= {1'b0, cnt_ff} == n_ff - CNT_BITS'(1);
      if (issuing) cnt_ff <= cnt_ff + VTX_BITS'(1);
      if (state_ff == ST_SCAN) begin
         wait_ff <= wait_ff + WAIT_BITS'(1);
      end else begin
         wait_ff <= '0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            a_ff   <= in_row;
            b_ff   <= in_col;
            w_ff   <= in_w;
            src_ff <= in_start;
            n_ff   <= n_eff;
            cnt_ff <= '0;
            step_ff <= CNT_BITS'(1);
            // hold a pending result word
            if (!rsp_v_ff) begin
               rsp_last_ff <= 1'b1;
               rsp_ev_ff   <= 1'b0;
               rsp_from_ff <= '0;
               rsp_to_ff   <= '0;
               rsp_w_ff    <= '0;
            end
         end
         ST_EMIT: begin
            if (!rsp_v_ff) begin
               rsp_ev_ff   <= best.found;
               rsp_last_ff <= !best.found || step_ff == n_ff - CNT_BITS'(1);
               rsp_from_ff <= best.found ? best.pred : '0;
               rsp_to_ff   <= best.found ? best.idx : '0;
               rsp_w_ff    <= best.found ? best.cost : '0;
               src_ff      <= best.idx;
               cnt_ff      <= '0;
               step_ff     <= step_ff + CNT_BITS'(1);
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ev_ff;
   assign rsp_tdata  = {8'd0, rsp_w_ff, rsp_to_ff, rsp_from_ff};

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_IDLE) else $error("ready outside idle");
   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && !rsp_tready |=> rsp_v_ff) else $error("result dropped");
   a_no_mark_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.mark |-> !rsp_v_ff) else $error("mark while result pending");
endmodule
`default_nettype wire
